// File: rtl/mepg_pkg.sv
// Shared widths, codes and beat types for the midpoint ellipse point generator.
`timescale 1ns / 1ps

package mepg_pkg;

  localparam int RADIUS_BITS = 11;
  localparam int COORD_BITS  = 12;
  localparam int COLOUR_BITS = 8;

  // Multiplier operand width: holds (2x+1)^2 as a positive signed value.
  localparam int MW = 2 * RADIUS_BITS + 3;
  // Width of the decision variable and the second-order differences.
  localparam int DW = 4 * RADIUS_BITS + 4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic STATUS_POINT = 1'b0;
  localparam logic STATUS_NONE  = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [RADIUS_BITS-1:0] radius_a;
    logic [RADIUS_BITS-1:0] radius_b;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic                   fill_flag;
    logic [COLOUR_BITS-1:0] colour;
  } item_t;

  typedef struct packed {
    logic                   status;
    logic [RADIUS_BITS-1:0] offset_x;
    logic [RADIUS_BITS-1:0] offset_y;
    logic [COORD_BITS-1:0]  out_center_x;
    logic [COORD_BITS-1:0]  out_center_y;
    logic                   out_fill;
    logic [COLOUR_BITS-1:0] out_colour;
    logic                   last_point;
  } res_t;

endpackage

// File: rtl/midpoint_ellipse_point_generator_unit.sv
// Top level of the midpoint ellipse point generator: handshakes, core and output register.
`timescale 1ns / 1ps

// Produces the first-quadrant points of an axis-aligned ellipse, one point per input beat.
// A start beat (mode 0) loads the semi-axes, centre, fill flag and colour and returns the
// point (0,b); each step beat (mode 1) returns the next point, with last_point set where y
// reaches zero, after which the ellipse is closed. A step beat with no open ellipse returns
// status 1 and all other fields zero. One beat is handled at a time, and in_stall stays high
// until its result has been moved into the output register. The work runs on one shared
// registered multiplier under a small sequencer. A start beat takes three chained products
// (a^2, b^2 and a^2*b), a region-1 step two products for the slope test, and the step that
// crosses into region 2 the slope test plus seven products that rebuild the decision and
// differences; a region-2 step needs no product, and a step beat that finds no open ellipse
// goes straight to its result. The output register lets a new beat be accepted while the
// previous point still waits on out_stall.

module midpoint_ellipse_point_generator_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mepg_pkg::item_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mepg_pkg::res_t  out_data
);
  import mepg_pkg::*;

  logic  core_idle;
  logic  core_res_valid;
  res_t  core_res;
  logic  res_take;
  logic  in_accept;
  logic  out_valid_r;
  res_t  out_data_r;

  // The core takes a new beat only between items.
  assign in_stall  = !core_idle;
  assign in_accept = in_valid && core_idle;

  // The output register can load when it is empty or is being drained this cycle.
  assign res_take = !out_valid_r || !out_stall;

  mepg_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_accept),
    .item_i      (in_data),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .res_take_i  (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && res_take) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/mepg_mult.sv
// Shared signed multiplier with a registered, truncated product.
`timescale 1ns / 1ps

module mepg_mult (
  input  logic                              clk,
  input  logic signed [mepg_pkg::MW-1:0]    op_a_i,
  input  logic signed [mepg_pkg::MW-1:0]    op_b_i,
  output logic signed [mepg_pkg::DW-1:0]    prod_o
);
  import mepg_pkg::*;

  logic signed [2*MW-1:0] full;
  logic signed [DW-1:0]   prod_r;

  assign full = op_a_i * op_b_i;

  // Only the low DW bits are kept; the arithmetic wraps like the difference registers.
  always_ff @(posedge clk) begin
    prod_r <= full[DW-1:0];
  end

  assign prod_o = prod_r;

endmodule

// File: rtl/mepg_core.sv
// Sequencer and difference registers of the ellipse generator around one shared multiplier.
`timescale 1ns / 1ps

module mepg_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  mepg_pkg::item_t item_i,
  output logic            idle_o,
  output logic            res_valid_o,
  output mepg_pkg::res_t  res_o,
  input  logic            res_take_i
);
  import mepg_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ST0  = 5'd1;
  localparam logic [4:0] S_ST1  = 5'd2;
  localparam logic [4:0] S_ST2  = 5'd3;
  localparam logic [4:0] S_ST3  = 5'd4;
  localparam logic [4:0] S_R1A  = 5'd5;
  localparam logic [4:0] S_R1B  = 5'd6;
  localparam logic [4:0] S_R1C  = 5'd7;
  localparam logic [4:0] S_E0   = 5'd8;
  localparam logic [4:0] S_E1   = 5'd9;
  localparam logic [4:0] S_E2   = 5'd10;
  localparam logic [4:0] S_E3   = 5'd11;
  localparam logic [4:0] S_E4   = 5'd12;
  localparam logic [4:0] S_E5   = 5'd13;
  localparam logic [4:0] S_E6   = 5'd14;
  localparam logic [4:0] S_E7   = 5'd15;
  localparam logic [4:0] S_R2   = 5'd16;
  localparam logic [4:0] S_EMIT = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       active_r, region2_r, nopoint_r;

  logic [RADIUS_BITS-1:0]   cur_x_r, cur_y_r;
  logic [2*RADIUS_BITS-1:0] a_sq_r, b_sq_r;
  logic signed [DW-1:0]     decision_r, de_r, dse_r, ds_r;
  logic signed [DW-1:0]     acc_r, aux_r;
  logic [COORD_BITS-1:0]    cx_r, cy_r;
  logic                     fill_r;
  logic [COLOUR_BITS-1:0]   col_r;

  logic signed [DW-1:0] p;
  logic signed [DW-1:0] asq_d, bsq_d;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [MW-1:0] asq_m, bsq_m, y_m, y2m1_m, xp1_m, tx_m, ym_m, k_m, x2p2_m;
  logic                 r1_go;

  mepg_mult u_mult (
    .clk    (clk),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (p)
  );

  assign asq_d  = {{(DW-2*RADIUS_BITS){1'b0}}, a_sq_r};
  assign bsq_d  = {{(DW-2*RADIUS_BITS){1'b0}}, b_sq_r};
  assign asq_m  = {{(MW-2*RADIUS_BITS){1'b0}}, a_sq_r};
  assign bsq_m  = {{(MW-2*RADIUS_BITS){1'b0}}, b_sq_r};
  assign y_m    = {{(MW-RADIUS_BITS){1'b0}}, cur_y_r};
  assign y2m1_m = {{(MW-RADIUS_BITS-1){1'b0}}, cur_y_r, 1'b0} - MW'(1);
  assign xp1_m  = {{(MW-RADIUS_BITS){1'b0}}, cur_x_r} + MW'(1);
  assign tx_m   = {{(MW-RADIUS_BITS-1){1'b0}}, cur_x_r, 1'b1};
  assign ym_m   = {{(MW-RADIUS_BITS){1'b0}}, cur_y_r} - MW'(1);
  assign k_m    = MW'(3) - {{(MW-RADIUS_BITS-1){1'b0}}, cur_y_r, 1'b0};
  assign x2p2_m = {{(MW-RADIUS_BITS-1){1'b0}}, cur_x_r, 1'b0} + MW'(2);

  // Region-1 slope test: a^2*(2y-1) (held in acc_r) against 2*b^2*(x+1).
  assign r1_go = acc_r > (p <<< 1);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_ST0: begin op_a = aux_r[MW-1:0]; op_b = aux_r[MW-1:0]; end
      S_ST1: begin op_a = y_m;           op_b = y_m;           end
      S_ST2: begin op_a = asq_m;         op_b = y_m;           end
      S_R1A: begin op_a = asq_m;         op_b = y2m1_m;        end
      S_R1B: begin op_a = bsq_m;         op_b = xp1_m;         end
      S_E0:  begin op_a = tx_m;          op_b = tx_m;          end
      S_E1:  begin op_a = ym_m;          op_b = ym_m;          end
      S_E2:  begin op_a = bsq_m;         op_b = acc_r[MW-1:0]; end
      S_E3:  begin op_a = asq_m;         op_b = aux_r[MW-1:0]; end
      S_E4:  begin op_a = asq_m;         op_b = bsq_m;         end
      S_E5:  begin op_a = asq_m;         op_b = k_m;           end
      S_E6:  begin op_a = bsq_m;         op_b = x2p2_m;        end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          priority if (item_i.mode == MODE_START) state_nxt = S_ST0;
          else if (!active_r)                     state_nxt = S_EMIT;
          else if (region2_r)                     state_nxt = S_R2;
          else                                    state_nxt = S_R1A;
        end
      end
      S_ST0: state_nxt = S_ST1;
      S_ST1: state_nxt = S_ST2;
      S_ST2: state_nxt = S_ST3;
      S_ST3: state_nxt = S_EMIT;
      S_R1A: state_nxt = S_R1B;
      S_R1B: state_nxt = S_R1C;
      S_R1C: state_nxt = r1_go ? S_EMIT : S_E0;
      S_E0:  state_nxt = S_E1;
      S_E1:  state_nxt = S_E2;
      S_E2:  state_nxt = S_E3;
      S_E3:  state_nxt = S_E4;
      S_E4:  state_nxt = S_E5;
      S_E5:  state_nxt = S_E6;
      S_E6:  state_nxt = S_E7;
      S_E7:  state_nxt = S_R2;
      S_R2:  state_nxt = S_EMIT;
      S_EMIT: if (res_take_i) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= 1'b0;
      region2_r <= 1'b0;
      nopoint_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start_i) begin
        if (item_i.mode == MODE_START) begin
          active_r  <= 1'b1;
          region2_r <= 1'b0;
          nopoint_r <= 1'b0;
        end else begin
          nopoint_r <= !active_r;
        end
      end
      if (state_r == S_E7) region2_r <= 1'b1;
      // The point with y at zero closes the ellipse.
      if (state_r == S_EMIT && res_take_i && !nopoint_r && cur_y_r == '0) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start_i && item_i.mode == MODE_START) begin
          aux_r   <= {{(DW-RADIUS_BITS){1'b0}}, item_i.radius_a};
          cur_x_r <= '0;
          cur_y_r <= item_i.radius_b;
          cx_r    <= item_i.center_x;
          cy_r    <= item_i.center_y;
          fill_r  <= item_i.fill_flag;
          col_r   <= item_i.colour;
        end
      end
      S_ST1: a_sq_r <= p[2*RADIUS_BITS-1:0];
      S_ST2: b_sq_r <= p[2*RADIUS_BITS-1:0];
      S_ST3: begin
        // p holds a^2*b here.
        decision_r <= (bsq_d <<< 2) - (p <<< 2) + asq_d;
        de_r       <= (bsq_d <<< 3) + (bsq_d <<< 2);
        dse_r      <= (bsq_d <<< 3) + (bsq_d <<< 2) + (asq_d <<< 3) - (p <<< 3);
        ds_r       <= '0;
      end
      S_R1B: acc_r <= p;
      S_R1C: begin
        if (r1_go) begin
          cur_x_r <= cur_x_r + 1'b1;
          de_r    <= de_r + (bsq_d <<< 3);
          if (decision_r[DW-1]) begin
            decision_r <= decision_r + de_r;
            dse_r      <= dse_r + (bsq_d <<< 3);
          end else begin
            decision_r <= decision_r + dse_r;
            dse_r      <= dse_r + ((bsq_d + asq_d) <<< 3);
            cur_y_r    <= cur_y_r - 1'b1;
          end
        end
      end
      S_E1: acc_r <= p;
      S_E2: aux_r <= p;
      S_E3: acc_r <= p;
      S_E4: acc_r <= acc_r + (p <<< 2);
      S_E5: decision_r <= acc_r - (p <<< 2);
      S_E6: begin
        ds_r  <= p <<< 2;
        acc_r <= p <<< 2;
      end
      S_E7: dse_r <= acc_r + (p <<< 2);
      S_R2: begin
        cur_y_r <= cur_y_r - 1'b1;
        ds_r    <= ds_r + (asq_d <<< 3);
        if (!decision_r[DW-1]) begin
          decision_r <= decision_r + ds_r;
          dse_r      <= dse_r + (asq_d <<< 3);
        end else begin
          decision_r <= decision_r + dse_r;
          dse_r      <= dse_r + ((asq_d + bsq_d) <<< 3);
          cur_x_r    <= cur_x_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o      = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_EMIT);

  always_comb begin
    res_o = '0;
    if (nopoint_r) begin
      res_o.status = STATUS_NONE;
    end else begin
      res_o.status       = STATUS_POINT;
      res_o.offset_x     = cur_x_r;
      res_o.offset_y     = cur_y_r;
      res_o.out_center_x = cx_r;
      res_o.out_center_y = cy_r;
      res_o.out_fill     = fill_r;
      res_o.out_colour   = col_r;
      res_o.last_point   = (cur_y_r == '0);
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == S_IDLE)
    else $error("new beat handed to the core while it is busy");

  a_r2_steps_y: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_R2 |=> cur_y_r == $past(cur_y_r) - RADIUS_BITS'(1))
    else $error("region-2 step did not lower y by one");

  a_step_on_live_arc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R1A || state_r == S_R2 || state_r == S_E0) |-> active_r && cur_y_r != '0)
    else $error("arc step taken without a live ellipse above y zero");

  a_region_switch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_E7 |=> region2_r && state_r == S_R2)
    else $error("region-2 entry did not set the region flag");

endmodule
